@@ hw/rtl/pis_pkg.sv @@
`default_nettype none

package pis_pkg;

    // Width of one page number on the streams
    localparam int PAGE_W = 7;

    // Beat widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Item kinds carried in the slave-side tuser
    typedef enum logic {
        KIND_RULE = 1'b0,
        KIND_PAGE = 1'b1
    } t_kind;

endpackage

`default_nettype wire

@@ hw/rtl/pis_prec_mem.sv @@
`default_nettype none

module pis_prec_mem #(
    parameter int PAGES = 128
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(PAGES)-1:0]   i_waddr,
    input  wire logic [PAGES-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(PAGES)-1:0]   i_raddr,
    output logic      [PAGES-1:0]           o_rdata
);

    // One row per earlier page, one bit per later page
    logic [PAGES-1:0] r_mem [PAGES];
    logic [PAGES-1:0] r_rdata;

    // Write one row a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered row read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/precedence_insertion_sorter_core.sv @@
// Rule beat: a row read, then the row write back. Page beat: a scan that compares one
// buffered page per cycle against the page's matrix row, then the insert into the list.
// A dropped page (buffer full) is not scanned. After a last-marked page, pages go out
// one per cycle while the master side is ready; the block takes no beat during a list's emission.
// Reset (i_rst_n low, synchronous) empties the list; the matrix is then cleared by a
// pass over all PAGES rows, one row a cycle, before the first beat is taken.
`default_nettype none

module precedence_insertion_sorter_core #(
    parameter int PAGES   = 128,
    parameter int MAX_LEN = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // slave side
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [pis_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [6:0] page, [13:7] later_page
    input  wire logic                       i_s_axis_tuser,     // [0] kind
    input  wire logic                       i_s_axis_tlast,     // last_in_update
    // master side
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [pis_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,     // [6:0] out_page
    output logic                            o_m_axis_tuser,     // [0] overflowed
    output logic                            o_m_axis_tlast      // out_last
);

    import pis_pkg::*;

    localparam int AW = $clog2(PAGES);
    localparam int XW = AW + PAGE_W;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int BW = $clog2(MAX_LEN);
    localparam logic [XW-1:0] PAGES_X = XW'(PAGES);
    localparam logic [CW-1:0] FULL    = CW'(MAX_LEN);
    localparam logic [AW-1:0] LAST_ROW = AW'(PAGES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RULE,
        S_SCAN,
        S_INSERT,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [PAGE_W-1:0]   r_page;
    logic [PAGE_W-1:0]   r_later;
    logic                r_last;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic                r_drop;
    logic [PAGE_W-1:0]   r_buf [MAX_LEN];
    logic                r_ovalid;
    logic [PAGE_W-1:0]   r_opage;
    logic                r_olast;
    logic                r_oflag;

    logic                s_accept;
    logic [PAGE_W-1:0]   in_page;
    logic [PAGE_W-1:0]   in_later;
    logic [XW-1:0]       in_page_x;
    logic [XW-1:0]       page_x;
    logic [XW-1:0]       later_x;
    logic [XW-1:0]       cand_x;
    logic                page_ok;
    logic                rule_ok;
    logic                cand_ok;
    logic [PAGE_W-1:0]   cand;
    logic                hit;
    logic                out_free;
    logic                emit_end;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [PAGES-1:0]    mem_wdata;
    logic [PAGES-1:0]    row;

    // Unpack the slave beat
    assign in_page   = i_s_axis_tdata[PAGE_W-1:0];
    assign in_later  = i_s_axis_tdata[2*PAGE_W-1:PAGE_W];
    assign in_page_x = XW'(in_page);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Range checks on the held page numbers
    assign page_x  = XW'(r_page);
    assign later_x = XW'(r_later);
    assign page_ok = page_x < PAGES_X;
    assign rule_ok = page_ok && (later_x < PAGES_X);

    // Shared compare: one buffered page against the new page's row
    assign cand    = r_buf[r_idx[BW-1:0]];
    assign cand_x  = XW'(cand);
    assign cand_ok = cand_x < PAGES_X;
    assign hit     = (r_idx != r_count) && page_ok && cand_ok && row[cand_x[AW-1:0]];

    assign out_free = !r_ovalid || i_m_axis_tready;
    assign emit_end = (r_idx + CW'(1)) == r_count;

    // Matrix write port: clearing pass or rule write back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_RULE: begin
                mem_we    = rule_ok;
                mem_waddr = page_x[AW-1:0];
                mem_wdata = row | (PAGES'(1) << later_x[AW-1:0]);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    pis_prec_mem #(
        .PAGES (PAGES)
    ) u_prec_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (s_accept),
        .i_raddr (in_page_x[AW-1:0]),
        .o_rdata (row)
    );

    // Sequencer, list buffer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the output beat once taken
            if (r_ovalid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_page  <= in_page;
                        r_later <= in_later;
                        r_last  <= i_s_axis_tlast;
                        r_idx   <= '0;
                        if (t_kind'(i_s_axis_tuser) == KIND_RULE) begin
                            r_state <= S_RULE;
                        end else if (r_count == FULL) begin
                            r_drop <= 1'b1;
                            if (i_s_axis_tlast) begin
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_RULE: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // stop at the first page this one must precede, or at the end
                    if (hit || (r_idx == r_count)) begin
                        r_pos   <= r_idx;
                        r_state <= S_INSERT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_INSERT: begin
                    for (int j = 0; j < MAX_LEN; j++) begin
                        if (CW'(j) == r_pos) begin
                            r_buf[j] <= r_page;
                        end else if (j > 0 && CW'(j) > r_pos && CW'(j) <= r_count) begin
                            r_buf[j] <= r_buf[(j > 0) ? j - 1 : 0];
                        end
                    end
                    r_count <= r_count + CW'(1);
                    r_idx   <= '0;
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    // one page per beat, in buffer order
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_opage  <= cand;
                        r_olast  <= emit_end;
                        r_oflag  <= r_drop;
                        r_idx    <= r_idx + CW'(1);
                        if (emit_end) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_opage);
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oflag;

endmodule

`default_nettype wire
